// ===== sv/bts_pkg.sv =====
// ----------------------------------------------------------------------------
// Bilinear texture sampler package
// Shared constants and types for the wrapped bilinear texture sampler.
// ----------------------------------------------------------------------------
package bts_pkg;

    localparam int DEFAULT_MAX_ROWS = 256;
    localparam int DEFAULT_MAX_COLS = 256;

    localparam int CFG_W   = 9;
    localparam int CFG_IDX = 1;
    localparam int FRAC_W  = 16;
    localparam int WGT_W   = 17;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [CFG_IDX-1:0] REG_TEX_ROWS = 1'b0;
    localparam logic [CFG_IDX-1:0] REG_TEX_COLS = 1'b1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } texel_t;

endpackage

// ===== sv/bts_addr.sv =====
// ----------------------------------------------------------------------------
// Sampler address stage
// Scales the coordinate fractions, forms neighbor indices and Q16 weights.
// Two register stages.
// ----------------------------------------------------------------------------
module bts_addr #(
    parameter int MAX_ROWS = bts_pkg::DEFAULT_MAX_ROWS,
    parameter int MAX_COLS = bts_pkg::DEFAULT_MAX_COLS,
    localparam int RW = $clog2(MAX_ROWS),
    localparam int CW = $clog2(MAX_COLS),
    localparam int RN = $clog2(MAX_ROWS + 1),
    localparam int CN = $clog2(MAX_COLS + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic [bts_pkg::FRAC_W-1:0]      frac_u,
    input  logic [bts_pkg::FRAC_W-1:0]      frac_v,
    input  logic [RN-1:0]                   rows,
    input  logic [CN-1:0]                   cols,
    output logic                            out_valid,
    output logic [RW-1:0]                   r1,
    output logic [RW-1:0]                   r2,
    output logic [CW-1:0]                   c1,
    output logic [CW-1:0]                   c2,
    output logic [bts_pkg::WGT_W-1:0]       dr,
    output logic [bts_pkg::WGT_W-1:0]       dc
);

    localparam int PRW = bts_pkg::FRAC_W + RN;
    localparam int PCW = bts_pkg::FRAC_W + CN;

    logic           v1_reg;
    logic [PRW-1:0] pr_reg;
    logic [PCW-1:0] pc_reg;
    logic [RN-1:0]  rows_reg;
    logic [CN-1:0]  cols_reg;
    logic           v2_reg;
    logic [RW-1:0]  r1_reg, r2_reg;
    logic [CW-1:0]  c1_reg, c2_reg;
    logic [bts_pkg::WGT_W-1:0] dr_reg, dc_reg;
    logic [RN-1:0]  r1_full;
    logic [CN-1:0]  c1_full;
    logic [RN:0]    r1_inc;
    logic [CN:0]    c1_inc;
    logic [RW-1:0]  r2_next;
    logic [CW-1:0]  c2_next;

    always_comb
    begin
        r1_full = pr_reg[PRW-1:bts_pkg::FRAC_W];
        c1_full = pc_reg[PCW-1:bts_pkg::FRAC_W];
        r1_inc  = {1'b0, r1_full} + 1'b1;
        c1_inc  = {1'b0, c1_full} + 1'b1;
        r2_next = (r1_inc < {1'b0, rows_reg}) ? r1_inc[RW-1:0] : '0;
        c2_next = (c1_inc < {1'b0, cols_reg}) ? c1_inc[CW-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pr_reg   <= PRW'(frac_u) * PRW'(rows);
        pc_reg   <= PCW'(frac_v) * PCW'(cols);
        rows_reg <= rows;
        cols_reg <= cols;
        r1_reg   <= r1_full[RW-1:0];
        c1_reg   <= c1_full[CW-1:0];
        r2_reg   <= r2_next;
        c2_reg   <= c2_next;
        dr_reg   <= 17'h10000 - {1'b0, pr_reg[bts_pkg::FRAC_W-1:0]};
        dc_reg   <= 17'h10000 - {1'b0, pc_reg[bts_pkg::FRAC_W-1:0]};
    end

    assign out_valid = v2_reg;
    assign r1 = r1_reg;
    assign r2 = r2_reg;
    assign c1 = c1_reg;
    assign c2 = c2_reg;
    assign dr = dr_reg;
    assign dc = dc_reg;

endmodule

// ===== sv/bts_store.sv =====
// ----------------------------------------------------------------------------
// Texel store
// Four banked copies of the texel memory, one per neighbor read port.
// Every load writes all copies; read data is registered.
// ----------------------------------------------------------------------------
module bts_store #(
    parameter int MAX_ROWS = bts_pkg::DEFAULT_MAX_ROWS,
    parameter int MAX_COLS = bts_pkg::DEFAULT_MAX_COLS,
    localparam int RW = $clog2(MAX_ROWS),
    localparam int CW = $clog2(MAX_COLS)
) (
    input  logic                    clk,
    input  logic                    wr_en,
    input  logic [RW-1:0]           wr_row,
    input  logic [CW-1:0]           wr_col,
    input  bts_pkg::texel_t         wr_data,
    input  logic [3:0][RW-1:0]      rd_row,
    input  logic [3:0][CW-1:0]      rd_col,
    output bts_pkg::texel_t [3:0]   rd_data
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);

    logic [AW-1:0] wr_addr;

    assign wr_addr = AW'(wr_row * MAX_COLS + wr_col);

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        bts_pkg::texel_t mem [DEPTH];
        bts_pkg::texel_t rd_reg;
        logic [AW-1:0]   rd_addr;

        assign rd_addr = AW'(rd_row[b] * MAX_COLS + rd_col[b]);

        always_ff @(posedge clk)
        begin
            if (wr_en)
            begin
                mem[wr_addr] <= wr_data;
            end
            rd_reg <= mem[rd_addr];
        end

        assign rd_data[b] = rd_reg;
    end

endmodule

// ===== sv/bts_blend.sv =====
// ----------------------------------------------------------------------------
// Bilinear blend
// Forms the four Q32 weights, multiplies per channel and rounds the sum.
// Three register stages.
// ----------------------------------------------------------------------------
module bts_blend (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [bts_pkg::WGT_W-1:0]  dr,
    input  logic [bts_pkg::WGT_W-1:0]  dc,
    input  bts_pkg::texel_t [3:0]      texels,
    output logic                       out_valid,
    output logic [15:0]                red,
    output logic [15:0]                green,
    output logic [15:0]                blue
);

    logic                  v1_reg, v2_reg, v3_reg;
    logic [3:0][32:0]      w_reg;
    bts_pkg::texel_t [3:0] t_reg;
    logic [2:0][3:0][40:0] p_reg;
    logic [2:0][15:0]      o_reg;
    logic [16:0]           drn, dcn;
    logic [2:0][3:0][7:0]  chan;
    logic [2:0][42:0]      sum;

    always_comb
    begin
        drn = 17'h10000 - dr;
        dcn = 17'h10000 - dc;
        for (int k = 0; k < 4; k++)
        begin
            chan[0][k] = t_reg[k].red;
            chan[1][k] = t_reg[k].green;
            chan[2][k] = t_reg[k].blue;
        end
        for (int ch = 0; ch < 3; ch++)
        begin
            sum[ch] = 43'(p_reg[ch][0]) + 43'(p_reg[ch][1]) + 43'(p_reg[ch][2])
                    + 43'(p_reg[ch][3]) + 43'(24'h800000);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg[0] <= 33'(34'(dr) * 34'(dc));
        w_reg[1] <= 33'(34'(dr) * 34'(dcn));
        w_reg[2] <= 33'(34'(drn) * 34'(dc));
        w_reg[3] <= 33'(34'(drn) * 34'(dcn));
        t_reg    <= texels;
        for (int ch = 0; ch < 3; ch++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                p_reg[ch][k] <= 41'(chan[ch][k]) * 41'(w_reg[k]);
            end
            o_reg[ch] <= sum[ch][39:24];
        end
    end

    assign out_valid = v3_reg;
    assign red       = o_reg[0];
    assign green     = o_reg[1];
    assign blue      = o_reg[2];

endmodule

// ===== sv/bilinear_texture_sampler_wrap.sv =====
// ----------------------------------------------------------------------------
// Bilinear texture sampler with repeat addressing
// Loads RGB texels into a banked store and returns bilinear samples.
// ----------------------------------------------------------------------------
// Channel  | Ports                                           | Handshake
// config   | cfg_we, cfg_index, cfg_data                     | write on cfg_we
// command  | start, busy, command, texel_*, coord_u, coord_v | start && !busy
// result   | done, out_red, out_green, out_blue              | done, one cycle
//
// One transaction enters every cycle; busy is always low.
// A sample result appears on done after two address stages, one registered
// memory read and three blend stages.
// A load writes the store from its delay registers, in step with the read
// of a sample, so a sample sees exactly the loads accepted before it.
// Reset clears valid bits and sets both sizes to 256; the store is undefined.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler_wrap #(
    parameter int MAX_ROWS = bts_pkg::DEFAULT_MAX_ROWS,
    parameter int MAX_COLS = bts_pkg::DEFAULT_MAX_COLS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bts_pkg::CFG_IDX-1:0]   cfg_index,
    input  logic [bts_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          start,
    output logic                          busy,
    input  logic                          command,
    input  logic [7:0]                    texel_row,
    input  logic [7:0]                    texel_col,
    input  logic [7:0]                    texel_red,
    input  logic [7:0]                    texel_green,
    input  logic [7:0]                    texel_blue,
    input  logic signed [31:0]            coord_u,
    input  logic signed [31:0]            coord_v,
    output logic                          done,
    output logic [15:0]                   out_red,
    output logic [15:0]                   out_green,
    output logic [15:0]                   out_blue
);

    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);
    localparam int RN = $clog2(MAX_ROWS + 1);
    localparam int CN = $clog2(MAX_COLS + 1);

    logic [bts_pkg::CFG_W-1:0] rows_reg, cols_reg;
    logic [RN-1:0]             rows_eff;
    logic [CN-1:0]             cols_eff;
    logic                      accept, sample, load;
    logic                      addr_valid;
    logic [RW-1:0]             r1, r2;
    logic [CW-1:0]             c1, c2;
    logic [bts_pkg::WGT_W-1:0] dr, dc;
    logic                      rd_valid_reg;
    logic [bts_pkg::WGT_W-1:0] dr_reg, dc_reg;
    bts_pkg::texel_t [3:0]     rd_data;
    bts_pkg::texel_t           wr_data;
    logic                      wr_ok;
    logic [1:0]                wr_en_reg;
    logic [1:0][RW-1:0]        wr_row_reg;
    logic [1:0][CW-1:0]        wr_col_reg;
    bts_pkg::texel_t [1:0]     wr_data_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign sample = accept && (command == bts_pkg::CMD_SAMPLE);
    assign load   = accept && (command == bts_pkg::CMD_LOAD);

    always_comb
    begin
        if (rows_reg == '0)
            rows_eff = RN'(1);
        else if (32'(rows_reg) > MAX_ROWS)
            rows_eff = RN'(MAX_ROWS);
        else
            rows_eff = RN'(rows_reg);
        if (cols_reg == '0)
            cols_eff = CN'(1);
        else if (32'(cols_reg) > MAX_COLS)
            cols_eff = CN'(MAX_COLS);
        else
            cols_eff = CN'(cols_reg);
        wr_ok = (32'(texel_row) < MAX_ROWS) && (32'(texel_col) < MAX_COLS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg     <= 9'd256;
            cols_reg     <= 9'd256;
            rd_valid_reg <= 1'b0;
            wr_en_reg    <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == bts_pkg::REG_TEX_ROWS)
                rows_reg <= cfg_data;
            if (cfg_we && cfg_index == bts_pkg::REG_TEX_COLS)
                cols_reg <= cfg_data;
            rd_valid_reg <= addr_valid;
            wr_en_reg    <= {wr_en_reg[0], load && wr_ok};
        end
    end

    always_ff @(posedge clk)
    begin
        dr_reg      <= dr;
        dc_reg      <= dc;
        wr_row_reg  <= {wr_row_reg[0], RW'(texel_row)};
        wr_col_reg  <= {wr_col_reg[0], CW'(texel_col)};
        wr_data_reg <= {wr_data_reg[0], wr_data};
    end

    assign wr_data = '{red: texel_red, green: texel_green, blue: texel_blue};

    bts_addr #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_addr (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample),
        .frac_u    (coord_u[15:0]),
        .frac_v    (coord_v[15:0]),
        .rows      (rows_eff),
        .cols      (cols_eff),
        .out_valid (addr_valid),
        .r1        (r1),
        .r2        (r2),
        .c1        (c1),
        .c2        (c2),
        .dr        (dr),
        .dc        (dc)
    );

    bts_store #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_store (
        .clk     (clk),
        .wr_en   (wr_en_reg[1]),
        .wr_row  (wr_row_reg[1]),
        .wr_col  (wr_col_reg[1]),
        .wr_data (wr_data_reg[1]),
        .rd_row  ({r2, r2, r1, r1}),
        .rd_col  ({c2, c1, c2, c1}),
        .rd_data (rd_data)
    );

    bts_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rd_valid_reg),
        .dr        (dr_reg),
        .dc        (dc_reg),
        .texels    (rd_data),
        .out_valid (done),
        .red       (out_red),
        .green     (out_green),
        .blue      (out_blue)
    );

endmodule

// ===== sim/tb_bilinear_texture_sampler_wrap.sv =====
// ----------------------------------------------------------------------------
// Testbench for the wrapped bilinear texture sampler
// Loads texels and issues samples under several row and column settings.
// Each sample transaction is predicted in the bench and compared per channel
// with the result strobed on done; loads only update the bench's store copy.
// ----------------------------------------------------------------------------
module tb_bilinear_texture_sampler_wrap;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_COLS = bts_pkg::DEFAULT_MAX_COLS;
    localparam int CFG_W      = bts_pkg::CFG_W;
    localparam int CFG_IDX    = bts_pkg::CFG_IDX;
    localparam int SETTLE     = 12;
    localparam int STALL_MAX  = 3000;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } pixel_t;

    // A configuration row uses texel_row[0] as the register index and the low
    // bits of coord_u as the data.
    typedef struct packed {
        bit          is_cfg;
        logic        cmd;
        logic [7:0]  row;
        logic [7:0]  col;
        logic [23:0] rgb;
        logic [31:0] u;
        logic [31:0] v;
        bit          has_exp;
        logic [47:0] exp_px;
    } step_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic start = 1'b0;
    logic busy;
    logic command = bts_pkg::CMD_LOAD;
    logic [7:0] texel_row = '0, texel_col = '0;
    logic [7:0] texel_red = '0, texel_green = '0, texel_blue = '0;
    logic signed [31:0] coord_u = '0, coord_v = '0;
    logic done;
    logic [15:0] out_red, out_green, out_blue;

    bilinear_texture_sampler_wrap dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    logic [23:0] texels [0:65535];
    bit written [0:65535];
    logic [CFG_W-1:0] rows_reg = 9'd256;
    logic [CFG_W-1:0] cols_reg = 9'd256;
    pixel_t pending_px [$];
    int errors = 0;
    int loads_sent = 0;
    int samples_sent = 0;
    int samples_seen = 0;
    int stall_cnt = 0;
    bit gaps_on = 1'b1;

    function automatic int unsigned used_size(logic [CFG_W-1:0] n);
        if (n == 0)
            return 1;
        return (n > 256) ? 256 : n;
    endfunction

    function automatic void corners(input logic [31:0] u, input logic [31:0] v,
                                    output int unsigned r1, output int unsigned r2,
                                    output int unsigned c1, output int unsigned c2,
                                    output int unsigned fr, output int unsigned fc);
        int unsigned nr, nc, pr, pc;
        nr = used_size(rows_reg);
        nc = used_size(cols_reg);
        pr = u[15:0] * nr;
        pc = v[15:0] * nc;
        r1 = pr >> 16;
        c1 = pc >> 16;
        r2 = (r1 + 1 < nr) ? r1 + 1 : 0;
        c2 = (c1 + 1 < nc) ? c1 + 1 : 0;
        fr = pr & 16'hFFFF;
        fc = pc & 16'hFFFF;
    endfunction

    function automatic pixel_t blend_sample(logic [31:0] u, logic [31:0] v);
        int unsigned r1, r2, c1, c2, fr, fc;
        longint unsigned dr, dc, acc;
        longint unsigned w [4];
        logic [23:0] t [4];
        logic [15:0] ch_out [3];
        corners(u, v, r1, r2, c1, c2, fr, fc);
        dr = 65536 - fr;
        dc = 65536 - fc;
        w[0] = dr * dc;
        w[1] = dr * (65536 - dc);
        w[2] = (65536 - dr) * dc;
        w[3] = (65536 - dr) * (65536 - dc);
        t[0] = texels[r1 * STORE_COLS + c1];
        t[1] = texels[r1 * STORE_COLS + c2];
        t[2] = texels[r2 * STORE_COLS + c1];
        t[3] = texels[r2 * STORE_COLS + c2];
        for (int ch = 0; ch < 3; ch++)
        begin
            acc = 0;
            for (int k = 0; k < 4; k++)
                acc += longint'((t[k] >> (16 - 8 * ch)) & 24'hFF) * w[k];
            ch_out[ch] = 16'((acc + (64'd1 << 23)) >> 24);
        end
        return '{ch_out[0], ch_out[1], ch_out[2]};
    endfunction

    task automatic issue(logic cmd, logic [7:0] row, logic [7:0] col, logic [23:0] rgb,
                         logic [31:0] u, logic [31:0] v, bit has_exp, pixel_t exp_px);
        while (gaps_on && $urandom_range(99) < 8)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        command <= cmd;
        texel_row <= row;
        texel_col <= col;
        {texel_red, texel_green, texel_blue} <= rgb;
        coord_u <= u;
        coord_v <= v;
        do
            @(negedge clk);
        while (busy);
        @(posedge clk);
        if (cmd == bts_pkg::CMD_LOAD)
        begin
            texels[row * STORE_COLS + col] = rgb;
            written[row * STORE_COLS + col] = 1'b1;
            loads_sent++;
        end
        else
        begin
            pending_px.push_back(has_exp ? exp_px : blend_sample(u, v));
            samples_sent++;
        end
    endtask

    // Any neighbour that has never been loaded is loaded first with a random
    // color, so the sampler never reads an undefined texel.
    task automatic sample_at(logic [31:0] u, logic [31:0] v, logic [23:0] junk,
                             bit has_exp, pixel_t exp_px);
        int unsigned r1, r2, c1, c2, fr, fc;
        int unsigned rs [4];
        int unsigned cs [4];
        corners(u, v, r1, r2, c1, c2, fr, fc);
        rs = '{r1, r1, r2, r2};
        cs = '{c1, c2, c1, c2};
        for (int k = 0; k < 4; k++)
            if (!written[rs[k] * STORE_COLS + cs[k]])
                issue(bts_pkg::CMD_LOAD, 8'(rs[k]), 8'(cs[k]), 24'($urandom),
                      $urandom, $urandom, 0, '0);
        issue(bts_pkg::CMD_SAMPLE, 8'($urandom), 8'($urandom), junk, u, v, has_exp, exp_px);
    endtask

    task automatic write_reg(logic [CFG_IDX-1:0] idx, logic [CFG_W-1:0] val);
        start <= 1'b0;
        wait (pending_px.size() == 0);
        repeat (SETTLE) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == bts_pkg::REG_TEX_ROWS)
            rows_reg = val;
        else
            cols_reg = val;
    endtask

    step_t directed [] = '{
        '{0, bts_pkg::CMD_LOAD,   8'd0,   8'd0,   24'hFFFFFF, 32'h7FFFFFFF, 32'h80000000,
          0, '0},
        '{0, bts_pkg::CMD_LOAD,   8'd255, 8'd255, 24'h000000, 32'h0,        32'h0,
          0, '0},
        '{0, bts_pkg::CMD_SAMPLE, 8'd0,   8'd0,   24'hFFFFFF, 32'h0,        32'h0,
          1, {16'hFF00, 16'hFF00, 16'hFF00}},
        '{0, bts_pkg::CMD_SAMPLE, 8'd255, 8'd255, 24'h0,      32'h7FFF0000, 32'h80000000,
          1, {16'hFF00, 16'hFF00, 16'hFF00}},
        '{0, bts_pkg::CMD_SAMPLE, 8'd0,   8'd0,   24'h0,      32'hFFFFFFFF, 32'hFFFFFFFF,
          0, '0},
        '{0, bts_pkg::CMD_SAMPLE, 8'd0,   8'd0,   24'h0,      32'h00008000, 32'h00008000,
          0, '0},
        '{0, bts_pkg::CMD_SAMPLE, 8'd0,   8'd0,   24'h0,      32'h80007FFF, 32'h0000FFFF,
          0, '0},
        '{0, bts_pkg::CMD_LOAD,   8'd0,   8'd0,   24'h123456, 32'hFFFFFFFF, 32'hFFFFFFFF,
          0, '0},
        '{0, bts_pkg::CMD_SAMPLE, 8'd0,   8'd0,   24'h0,      32'h00010000, 32'hFFFF0000,
          1, {16'h1200, 16'h3400, 16'h5600}},
        '{1, bts_pkg::CMD_LOAD,   8'd0,   8'd0,   24'h0,      32'd1,        32'h0,
          0, '0},
        '{1, bts_pkg::CMD_LOAD,   8'd1,   8'd0,   24'h0,      32'd0,        32'h0,
          0, '0},
        '{0, bts_pkg::CMD_SAMPLE, 8'd0,   8'd0,   24'h0,      32'h1234ABCD, 32'hDEADBEEF,
          1, {16'h1200, 16'h3400, 16'h5600}},
        '{1, bts_pkg::CMD_LOAD,   8'd0,   8'd0,   24'h0,      32'd511,      32'h0,
          0, '0},
        '{1, bts_pkg::CMD_LOAD,   8'd1,   8'd0,   24'h0,      32'd2,        32'h0,
          0, '0},
        '{0, bts_pkg::CMD_SAMPLE, 8'd0,   8'd0,   24'h0,      32'hFFFFFFFF, 32'hFFFFFFFF,
          0, '0},
        '{0, bts_pkg::CMD_SAMPLE, 8'd0,   8'd0,   24'h0,      32'h00004000, 32'hFFFF8000,
          0, '0}
    };

    int unsigned phase_rows [] = '{256, 1, 2, 511, 256, 3, 17, 100};
    int unsigned phase_cols [] = '{256, 256, 3, 0, 1, 2, 5, 256};

    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && done)
        begin
            if (pending_px.size() == 0)
            begin
                $display("%0t: result with no sample pending: %h %h %h",
                         $time, out_red, out_green, out_blue);
                errors++;
            end
            else
            begin
                want = pending_px.pop_front();
                samples_seen++;
                if (out_red !== want.red)
                begin
                    $display("%0t: out_red expected %h got %h", $time, want.red, out_red);
                    errors++;
                end
                if (out_green !== want.green)
                begin
                    $display("%0t: out_green expected %h got %h", $time, want.green,
                             out_green);
                    errors++;
                end
                if (out_blue !== want.blue)
                begin
                    $display("%0t: out_blue expected %h got %h", $time, want.blue, out_blue);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || cfg_we || !rst_n)
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt > STALL_MAX)
        begin
            $display("%0t: no progress, %0d samples still pending", $time, pending_px.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        int n;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].is_cfg)
                write_reg(directed[i].row[0], directed[i].u[CFG_W-1:0]);
            else if (directed[i].cmd == bts_pkg::CMD_LOAD)
                issue(bts_pkg::CMD_LOAD, directed[i].row, directed[i].col, directed[i].rgb,
                      directed[i].u, directed[i].v, 0, '0);
            else
                sample_at(directed[i].u, directed[i].v, directed[i].rgb,
                          directed[i].has_exp, directed[i].exp_px);
        end

        foreach (phase_rows[p])
        begin
            write_reg(bts_pkg::REG_TEX_ROWS, 9'(phase_rows[p]));
            write_reg(bts_pkg::REG_TEX_COLS, 9'(phase_cols[p]));
            gaps_on = (p != 2);
            n = loads_sent + samples_sent;
            while (loads_sent + samples_sent < n + 230)
            begin
                if ($urandom_range(99) < 25)
                    issue(bts_pkg::CMD_LOAD, 8'($urandom), 8'($urandom), 24'($urandom),
                          $urandom, $urandom, 0, '0);
                else if ($urandom_range(9) == 0)
                    sample_at({$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)},
                              {16'($urandom), $urandom_range(1) ? 16'hFFFF : 16'h0001},
                              24'($urandom), 0, '0);
                else
                    sample_at($urandom, $urandom, 24'($urandom), 0, '0);
            end
        end
        gaps_on = 1'b1;
        start <= 1'b0;
        wait (pending_px.size() == 0);
        repeat (SETTLE) @(posedge clk);

        $display("Loaded %0d texels and sampled %0d times (%0d results checked)",
                 loads_sent, samples_sent, samples_seen);
        $display("Covered %0d size settings including 0, 1 and oversized, with wrapping",
                 phase_rows.size() + 2);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
